@@ hdl/sbq_pkg.sv @@
package sbq_pkg;

  localparam int BANDS_DEF        = 4;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;
  localparam int STATE_WIDTH      = 40;
  localparam int STATE_FRAC       = 16;
  localparam int COEFS_PER_BAND   = 5;
  localparam int STATES_PER_BAND  = 4;

  // input word function codes; the last one is unused and ignored
  typedef enum logic [1:0] {
    FUNC_PROC  = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_t;

  // coefficient slots within a band
  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_slot_t;

  // datapath micro steps for one band on one channel
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_RD,
    STEP_MB0,
    STEP_Y,
    STEP_MA1,
    STEP_S1,
    STEP_MA2,
    STEP_S2
  } step_t;

  typedef struct packed {
    logic  accept;
    step_t step;
    logic  ch;
    logic  out_load;
  } cmd_t;

endpackage

@@ hdl/sbq_if.sv @@
interface sbq_in_if #(
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = sbq_pkg::COEF_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic signed [SAMPLE_WIDTH-1:0] sample_left;
  logic signed [SAMPLE_WIDTH-1:0] sample_right;
  logic [1:0]                     coef_band;
  logic [2:0]                     coef_index;
  logic signed [COEF_WIDTH-1:0]   coef_value;

  modport source (output valid, func, sample_left, sample_right, coef_band, coef_index,
                  coef_value, input ready);
  modport sink   (input valid, func, sample_left, sample_right, coef_band, coef_index,
                  coef_value, output ready);
endinterface

interface sbq_out_if #(
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_left;
  logic signed [SAMPLE_WIDTH-1:0] out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

interface sbq_cfg_if #(
  parameter int BANDS = sbq_pkg::BANDS_DEF
);
  logic             valid;
  logic             ready;
  logic [BANDS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hdl/stereo_biquad_cascade_eq_top.sv @@
// A process word runs the bands in order after accept, and the input stays closed until
// its result is loaded into the output register, which waits there if the last result
// is not yet taken. Each enabled band runs the steps RD, MB0, Y, MA1, S1, MA2, S2 once
// per channel on the one shared multiplier and the registered coefficient and state
// memory reads; a disabled band only passes through the band state. Load and clear
// words leave the block idle; the next word is taken while a result waits. Reset (rst,
// synchronous, active high) clears band enable, coefficients and state.
module stereo_biquad_cascade_eq_top #(
  parameter int BANDS        = sbq_pkg::BANDS_DEF,
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = sbq_pkg::COEF_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  sbq_in_if.sink    din,
  sbq_out_if.source dout,
  sbq_cfg_if.sink   cfg
);

  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

  sbq_pkg::cmd_t cmd;
  logic [BW-1:0] band;

  sbq_ctrl #(.BANDS(BANDS), .BW(BW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .in_func   (din.func),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_data  (cfg.data),
    .cmd       (cmd),
    .band      (band)
  );

  sbq_datapath #(
    .BANDS(BANDS), .SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH), .BW(BW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .band         (band),
    .func         (din.func),
    .sample_left  (din.sample_left),
    .sample_right (din.sample_right),
    .coef_band    (din.coef_band),
    .coef_index   (din.coef_index),
    .coef_value   (din.coef_value),
    .out_left     (dout.out_left),
    .out_right    (dout.out_right)
  );

endmodule

@@ hdl/sbq_ctrl.sv @@
module sbq_ctrl #(
  parameter int BANDS = sbq_pkg::BANDS_DEF,
  parameter int BW    = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_func,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [BANDS-1:0] cfg_data,
  output sbq_pkg::cmd_t    cmd,
  output logic [BW-1:0]    band
);

  typedef enum logic [3:0] {
    S_IDLE, S_BAND, S_RD, S_MB0, S_Y, S_MA1, S_S1, S_MA2, S_S2, S_FINISH
  } state_t;

  state_t           state;
  logic             ch;
  logic [BANDS-1:0] band_enable;
  logic             accept;
  logic             last_band;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign last_band = (band == BW'(BANDS - 1));

  // decode the datapath command from the current state
  always_comb begin
    cmd.accept   = accept;
    cmd.ch       = ch;
    cmd.out_load = (state == S_FINISH) && (!out_valid || out_ready);
    case (state)
      S_RD:    cmd.step = sbq_pkg::STEP_RD;
      S_MB0:   cmd.step = sbq_pkg::STEP_MB0;
      S_Y:     cmd.step = sbq_pkg::STEP_Y;
      S_MA1:   cmd.step = sbq_pkg::STEP_MA1;
      S_S1:    cmd.step = sbq_pkg::STEP_S1;
      S_MA2:   cmd.step = sbq_pkg::STEP_MA2;
      S_S2:    cmd.step = sbq_pkg::STEP_S2;
      default: cmd.step = sbq_pkg::STEP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ch          <= 1'b0;
      band        <= '0;
      band_enable <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        band_enable <= cfg_data;
      end
      // drop the result once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (sbq_pkg::func_t'(in_func) == sbq_pkg::FUNC_PROC)) begin
            band  <= '0;
            ch    <= 1'b0;
            state <= S_BAND;
          end
        end
        S_BAND: begin
          if (band_enable[band]) begin
            state <= S_RD;
          end else if (last_band) begin
            state <= S_FINISH;
          end else begin
            band <= band + 1'b1;
          end
        end
        S_RD:  state <= S_MB0;
        S_MB0: state <= S_Y;
        S_Y:   state <= S_MA1;
        S_MA1: state <= S_S1;
        S_S1:  state <= S_MA2;
        S_MA2: state <= S_S2;
        S_S2: begin
          if (!ch) begin
            ch    <= 1'b1;
            state <= S_RD;
          end else begin
            ch <= 1'b0;
            if (last_band) begin
              state <= S_FINISH;
            end else begin
              band  <= band + 1'b1;
              state <= S_BAND;
            end
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/sbq_datapath.sv @@
module sbq_datapath #(
  parameter int BANDS        = sbq_pkg::BANDS_DEF,
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = sbq_pkg::COEF_WIDTH_DEF,
  parameter int BW           = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sbq_pkg::cmd_t                  cmd,
  input  logic [BW-1:0]                  band,
  input  logic [1:0]                     func,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_left,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_right,
  input  logic [1:0]                     coef_band,
  input  logic [2:0]                     coef_index,
  input  logic signed [COEF_WIDTH-1:0]   coef_value,
  output logic signed [SAMPLE_WIDTH-1:0] out_left,
  output logic signed [SAMPLE_WIDTH-1:0] out_right
);

  localparam int CN    = BANDS * sbq_pkg::COEFS_PER_BAND;
  localparam int SN    = BANDS * sbq_pkg::STATES_PER_BAND;
  localparam int CAW   = $clog2(CN);
  localparam int SAW   = $clog2(SN);
  localparam int STW   = sbq_pkg::STATE_WIDTH;
  localparam int FRAC  = sbq_pkg::STATE_FRAC;
  localparam int CF    = COEF_WIDTH - 4;
  localparam int PW    = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_W = (PW + 4 > STW + 2) ? PW + 4 : STW + 2;
  localparam int SH_R  = (CF >= FRAC) ? CF - FRAC : 0;
  localparam int SH_L  = (CF < FRAC) ? FRAC - CF : 0;

  localparam logic signed [ACC_W-1:0] Y_HI  = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Y_LO  = -Y_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_HI  = ACC_W'((64'sd1 <<< (STW - 1)) - 1);
  localparam logic signed [ACC_W-1:0] S_LO  = -S_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(64'sd1 <<< (FRAC - 1));

  // product brought to the state's fraction bits
  function automatic logic signed [ACC_W-1:0] scale(input logic signed [PW-1:0] p);
    logic signed [ACC_W-1:0] e;
    e = ACC_W'(p);
    return (e >>> SH_R) <<< SH_L;
  endfunction

  function automatic logic signed [STW-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = (v > S_HI) ? S_HI : ((v < S_LO) ? S_LO : v);
    return r[STW-1:0];
  endfunction

  logic signed [COEF_WIDTH-1:0]   cmem [CN];
  logic [CN-1:0]                  cvalid;
  logic signed [STW-1:0]          smem [SN];
  logic [SN-1:0]                  svalid;

  logic [CAW-1:0]                 c_raddr;
  logic [CAW-1:0]                 c_waddr;
  logic                           c_we;
  logic signed [COEF_WIDTH-1:0]   coef_q;
  logic                           coef_ok;
  logic [SAW-1:0]                 s_raddr;
  logic [SAW-1:0]                 s_waddr;
  logic                           s_we;
  logic signed [STW-1:0]          s_wdata;
  logic signed [STW-1:0]          st_q;
  logic                           st_ok;

  logic signed [SAMPLE_WIDTH-1:0] xl;
  logic signed [SAMPLE_WIDTH-1:0] xr;
  logic signed [SAMPLE_WIDTH-1:0] y;
  logic signed [SAMPLE_WIDTH-1:0] xs;
  logic signed [SAMPLE_WIDTH-1:0] mop;
  logic signed [COEF_WIDTH-1:0]   mcoef;
  logic signed [PW-1:0]           prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        s1h;
  logic signed [ACC_W-1:0]        s2h;
  logic signed [ACC_W-1:0]        sum_y;
  logic signed [ACC_W-1:0]        t_y;
  logic signed [ACC_W-1:0]        diff;
  logic [2:0]                     c_off;
  logic                           s_off;
  logic                           load_ok;

  assign xs    = cmd.ch ? xr : xl;
  assign mcoef = coef_ok ? coef_q : '0;

  // coefficient slot for each step
  always_comb begin
    case (cmd.step)
      sbq_pkg::STEP_RD:  c_off = sbq_pkg::COEF_B0;
      sbq_pkg::STEP_MB0: c_off = sbq_pkg::COEF_B1;
      sbq_pkg::STEP_Y:   c_off = sbq_pkg::COEF_A1;
      sbq_pkg::STEP_MA1: c_off = sbq_pkg::COEF_B2;
      sbq_pkg::STEP_S1:  c_off = sbq_pkg::COEF_A2;
      default:           c_off = sbq_pkg::COEF_B0;
    endcase
  end

  assign s_off   = (cmd.step == sbq_pkg::STEP_MB0);
  assign c_raddr = CAW'(int'(band) * sbq_pkg::COEFS_PER_BAND + int'(c_off));
  assign s_raddr = SAW'(int'(band) * sbq_pkg::STATES_PER_BAND + (cmd.ch ? 2 : 0)
                        + (s_off ? 1 : 0));
  assign s_waddr = SAW'(int'(band) * sbq_pkg::STATES_PER_BAND + (cmd.ch ? 2 : 0)
                        + ((cmd.step == sbq_pkg::STEP_S2) ? 1 : 0));

  // multiplier operand: band input or band output
  always_comb begin
    case (cmd.step)
      sbq_pkg::STEP_MA1, sbq_pkg::STEP_MA2: mop = y;
      default:                              mop = xs;
    endcase
  end

  // band output: round half up, saturate to sample width
  assign sum_y = scale(prod) + s1h + HALF;
  assign t_y   = sum_y >>> FRAC;
  assign diff  = acc - scale(prod);

  assign s_we    = (cmd.step == sbq_pkg::STEP_S1) || (cmd.step == sbq_pkg::STEP_S2);
  assign s_wdata = sat_state(diff);

  assign load_ok = (int'(coef_band) < BANDS) && (int'(coef_index) < sbq_pkg::COEFS_PER_BAND);
  assign c_we    = cmd.accept && (sbq_pkg::func_t'(func) == sbq_pkg::FUNC_LOAD) && load_ok;
  assign c_waddr = CAW'(int'(coef_band) * sbq_pkg::COEFS_PER_BAND + int'(coef_index));

  // valid bits stand in for the all-zero reset of both stores
  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
      svalid <= '0;
    end else begin
      if (c_we) begin
        cvalid[c_waddr] <= 1'b1;
      end
      if (cmd.accept && (sbq_pkg::func_t'(func) == sbq_pkg::FUNC_CLEAR)) begin
        svalid <= '0;
      end else if (s_we) begin
        svalid[s_waddr] <= 1'b1;
      end
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= coef_value;
    end
    coef_q  <= cmem[c_raddr];
    coef_ok <= cvalid[c_raddr];
  end

  // filter state memory
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    st_q  <= smem[s_raddr];
    st_ok <= svalid[s_raddr];
  end

  // shared multiplier and accumulator
  always_ff @(posedge clk) begin
    prod <= mcoef * mop;
    if (cmd.accept && (sbq_pkg::func_t'(func) == sbq_pkg::FUNC_PROC)) begin
      xl <= sample_left;
      xr <= sample_right;
    end
    case (cmd.step)
      sbq_pkg::STEP_MB0: s1h <= st_ok ? ACC_W'(st_q) : '0;
      sbq_pkg::STEP_Y: begin
        s2h <= st_ok ? ACC_W'(st_q) : '0;
        y   <= (t_y > Y_HI) ? Y_HI[SAMPLE_WIDTH-1:0] :
               ((t_y < Y_LO) ? Y_LO[SAMPLE_WIDTH-1:0] : t_y[SAMPLE_WIDTH-1:0]);
      end
      sbq_pkg::STEP_MA1: acc <= scale(prod) + s2h;
      sbq_pkg::STEP_MA2: acc <= scale(prod);
      sbq_pkg::STEP_S2: begin
        if (cmd.ch) begin
          xr <= y;
        end else begin
          xl <= y;
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_left  <= xl;
      out_right <= xr;
    end
  end

endmodule

@@ hdl/sbq_checker.sv @@
module sbq_checker #(
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              in_func,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_left,
  input logic [SAMPLE_WIDTH-1:0] out_right
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_left) && $stable(out_right))
    else $error("result word changed while stalled");

  // a process word keeps the input closed while it runs
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func == sbq_pkg::FUNC_PROC |=> !in_ready)
    else $error("input open during filtering");

  // load, clear and unused words make no result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func != sbq_pkg::FUNC_PROC |=> !$rose(out_valid))
    else $error("result from a non-process word");

endmodule

bind stereo_biquad_cascade_eq_top sbq_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sbq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .in_func   (din.func),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_left  (dout.out_left),
  .out_right (dout.out_right)
);

@@ dv/stereo_biquad_cascade_eq_top_tb.sv @@
`timescale 1ns / 1ps
module stereo_biquad_cascade_eq_top_tb;

  localparam int NB = sbq_pkg::BANDS_DEF;
  localparam int SW = sbq_pkg::SAMPLE_WIDTH_DEF;
  localparam int CW = sbq_pkg::COEF_WIDTH_DEF;
  localparam int CFRAC = CW - 4;
  localparam int SFRAC = sbq_pkg::STATE_FRAC;
  localparam int LIMIT = 2000000;
  localparam int HOLD_LEN = 300;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbq_in_if  #(.SAMPLE_WIDTH(SW), .COEF_WIDTH(CW)) din ();
  sbq_out_if #(.SAMPLE_WIDTH(SW)) dout ();
  sbq_cfg_if #(.BANDS(NB)) cfg ();

  stereo_biquad_cascade_eq_top #(.BANDS(NB), .SAMPLE_WIDTH(SW), .COEF_WIDTH(CW)) dut (
    .clk(clk), .rst(rst), .din(din.sink), .dout(dout.source), .cfg(cfg.sink)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [NB-1:0]          eq_enable;
  logic signed [CW-1:0]   eq_coef [NB*5];
  logic signed [39:0]     eq_mem [NB*4];
  pair_t                  filtered_q[$];

  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int pairs_checked = 0;
  int idle_pct = 19;
  int hold_cycles = 0;
  bit hold_req = 0;
  bit hold_done = 0;

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint coef_prod(longint c, longint x);
    return floor_shr(c * x, CFRAC - SFRAC);
  endfunction

  function automatic longint band_filter(int b, int ch, longint x);
    longint c0, c1, c2, c3, c4, s1, s2, acc, y, n1, n2;
    c0 = eq_coef[b*5+sbq_pkg::COEF_B0];
    c1 = eq_coef[b*5+sbq_pkg::COEF_B1];
    c2 = eq_coef[b*5+sbq_pkg::COEF_B2];
    c3 = eq_coef[b*5+sbq_pkg::COEF_A1];
    c4 = eq_coef[b*5+sbq_pkg::COEF_A2];
    s1 = eq_mem[b*4+ch*2];
    s2 = eq_mem[b*4+ch*2+1];
    acc = coef_prod(c0, x) + s1;
    y = clip(floor_shr(acc + (longint'(1) <<< (SFRAC - 1)), SFRAC), SW);
    n1 = coef_prod(c1, x) - coef_prod(c3, y) + s2;
    n2 = coef_prod(c2, x) - coef_prod(c4, y);
    eq_mem[b*4+ch*2]   = 40'(clip(n1, 40));
    eq_mem[b*4+ch*2+1] = 40'(clip(n2, 40));
    return y;
  endfunction

  // advance the predictor by one accepted word
  task automatic predict_word(logic [1:0] f, logic signed [SW-1:0] l_in,
                              logic signed [SW-1:0] r_in, logic [1:0] band,
                              logic [2:0] slot, logic signed [CW-1:0] val);
    longint l, r;
    pair_t p;
    if (f == sbq_pkg::FUNC_LOAD) begin
      if (band < NB && slot <= sbq_pkg::COEF_A2) eq_coef[band*5+slot] = val;
    end else if (f == sbq_pkg::FUNC_CLEAR) begin
      foreach (eq_mem[i]) eq_mem[i] = '0;
    end else if (f == sbq_pkg::FUNC_PROC) begin
      l = l_in;
      r = r_in;
      for (int b = 0; b < NB; b++) begin
        if (eq_enable[b]) begin
          l = band_filter(b, 0, l);
          r = band_filter(b, 1, r);
        end
      end
      p.left = SW'(l);
      p.right = SW'(r);
      filtered_q.push_back(p);
    end
  endtask

  // drive one word and wait for acceptance; valid stays up for the next word
  task automatic send_word(logic [1:0] f, logic signed [SW-1:0] l_in,
                           logic signed [SW-1:0] r_in, logic [1:0] band,
                           logic [2:0] slot, logic signed [CW-1:0] val);
    if ($urandom_range(99) < idle_pct) begin
      din.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    din.valid <= 1'b1;
    din.func <= f;
    din.sample_left <= l_in;
    din.sample_right <= r_in;
    din.coef_band <= band;
    din.coef_index <= slot;
    din.coef_value <= val;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    predict_word(f, l_in, r_in, band, slot, val);
    words_sent++;
  endtask

  task automatic send_pair(int l, int r);
    send_word(sbq_pkg::FUNC_PROC, SW'(l), SW'(r), $urandom, $urandom, $urandom);
  endtask

  task automatic load_coef(int band, int slot, int val);
    send_word(sbq_pkg::FUNC_LOAD, $urandom, $urandom, 2'(band), 3'(slot), CW'(val));
  endtask

  // drop valid, wait for all results, then let the block drain
  task automatic drain();
    din.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (3 + NB + 14 * NB + 10) @(posedge clk);
  endtask

  task automatic write_enable(logic [NB-1:0] v);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    eq_enable = v;
  endtask

  // a modest stable random band: small coefficients
  task automatic load_random_band(int band);
    for (int k = 0; k <= sbq_pkg::COEF_A2; k++)
      load_coef(band, k, $urandom_range(0, 1 << 27) - (1 << 26));
  endtask

  task automatic test_directed();
    // enabled band with zero coefficients outputs zero
    write_enable('1);
    send_pair(8388607, -8388608);
    write_enable('0);
    send_pair(8388607, -8388608);
    send_pair(0, -1);
    // identity gain on band 0, extreme coefficient values on band 1
    load_coef(0, sbq_pkg::COEF_B0, 1 << CFRAC);
    load_coef(1, sbq_pkg::COEF_B0, 32'h7fffffff);
    load_coef(1, sbq_pkg::COEF_B1, 32'h80000000);
    load_coef(1, sbq_pkg::COEF_A1, 32'h80000000);
    load_coef(1, sbq_pkg::COEF_A2, 32'h7fffffff);
    load_coef(1, sbq_pkg::COEF_B2, 32'h7fffffff);
    // out of range slots write nothing
    load_coef(0, 5, 32'h7fffffff);
    load_coef(0, 7, 32'h80000000);
    write_enable(4'b0001);
    send_pair(8388607, -8388608);
    write_enable(4'b0011);
    send_pair(8388607, -8388608);
    send_pair(-8388608, 8388607);
    send_pair(123456, -654321);
    send_word(sbq_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0);
    send_pair(1, -1);
    // unused function code is ignored
    send_word(sbq_pkg::FUNC_RSVD, SW'(-1), SW'(-1), 2'd3, 3'd7, '1);
    send_pair(-1, 1);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80)
        send_pair($urandom_range(0, 2 * 8388607 + 1) - 8388608,
                  $urandom_range(0, 2 * 8388607 + 1) - 8388608);
      else if (r < 85)
        send_pair($urandom_range(3) == 0 ? 8388607 : -8388608, $urandom_range(255) - 128);
      else if (r < 93)
        load_coef($urandom_range(3), $urandom_range(7),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1 << 28) - (1 << 27));
      else if (r < 96)
        send_word(sbq_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send_word(sbq_pkg::FUNC_RSVD, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_enable_sweep();
    logic [NB-1:0] settings [4] = '{4'b0000, 4'b1111, 4'b0101, 4'b1010};
    for (int b = 0; b < NB; b++) load_random_band(b);
    foreach (settings[i]) begin
      write_enable(settings[i]);
      test_random(110);
    end
  endtask

  task automatic test_backpressure();
    write_enable(4'b1111);
    hold_req = 1'b1;
    test_random(30);
    drain();
    // stretch with no idling at all
    idle_pct = 0;
    test_random(40);
    idle_pct = 19;
  endtask

  // result sink ready: random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      dout.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) hold_done <= 1'b1;
    end else begin
      dout.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    pair_t e;
    if (!rst && dout.valid && dout.ready) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected result left=%0d right=%0d", dout.out_left, dout.out_right);
        errors++;
      end else begin
        e = filtered_q.pop_front();
        pairs_checked++;
        if (dout.out_left !== e.left) begin
          $error("out_left expected %0d actual %0d", e.left, dout.out_left);
          errors++;
        end
        if (dout.out_right !== e.right) begin
          $error("out_right expected %0d actual %0d", e.right, dout.out_right);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("stereo_biquad_cascade_eq_top verification failed");
      $finish;
    end
  end

  initial begin
    din.valid = 1'b0;
    din.func = sbq_pkg::FUNC_PROC;
    din.sample_left = '0;
    din.sample_right = '0;
    din.coef_band = '0;
    din.coef_index = '0;
    din.coef_value = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    eq_enable = '0;
    foreach (eq_coef[i]) eq_coef[i] = '0;
    foreach (eq_mem[i]) eq_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_enable_sweep();
    test_backpressure();
    drain();
    $display("Covered %0d words, %0d filtered pairs checked, enable masks 0/1/3/5/A/F.",
             words_sent, pairs_checked);
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("stereo_biquad_cascade_eq_top verification clean");
    end else begin
      $display("stereo_biquad_cascade_eq_top verification failed");
    end
    $finish;
  end
endmodule
